// ===== rtl/ksa_pkg.sv =====
package ksa_pkg;

  // Default sizes
  localparam int QUEUE_DEPTH_DEF    = 32;
  localparam int ITEM_QUEUE_DEPTH   = 2;
  localparam int RESULT_QUEUE_DEPTH = 4;

  // Result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  // Keyboard command that sets the LEDs
  localparam logic [7:0] LED_CMD = 8'hed;

  // Scan codes with a meaning of their own
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2a;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'haa;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hb6;
  localparam logic [7:0] SC_CAPS_LOCK    = 8'h3a;
  localparam logic [7:0] SC_NUM_LOCK     = 8'h45;
  localparam logic [7:0] SC_SCROLL_LOCK  = 8'h46;
  localparam logic [7:0] SC_ACK          = 8'hfa;
  localparam logic [7:0] SC_RESEND       = 8'hfe;

  typedef enum logic [3:0] {
    CL_NONE,
    CL_LSHIFT_MAKE,
    CL_RSHIFT_MAKE,
    CL_LSHIFT_BREAK,
    CL_RSHIFT_BREAK,
    CL_CAPS,
    CL_NUM,
    CL_SCROLL,
    CL_ACK,
    CL_RESEND
  } ksa_class_t;

  // Classified scan code handed from front to back
  typedef struct packed {
    ksa_class_t  cls;
    logic [7:0]  plain_ch;
    logic [7:0]  shift_ch;
  } ksa_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  value;
    logic        last;
  } ksa_result_t;

  typedef enum logic [1:0] {
    ST_EXEC,
    ST_LED2,
    ST_CFG2,
    ST_SEND
  } ksa_state_t;

endpackage

// ===== rtl/ksa_fifo.sv =====
module ksa_fifo import ksa_pkg::*; #(
  parameter int DEPTH = ITEM_QUEUE_DEPTH,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ksa_front.sv =====
module ksa_front import ksa_pkg::*; (
  input  logic       push,
  input  logic [7:0] scan_code,
  output logic       full,
  input  logic       q_full,
  output logic       q_push,
  output ksa_item_t  q_item
);

  localparam logic [7:0] PLAIN_MAP [128] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h40, 8'h5b, 8'h0a, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
    8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00
  };

  localparam logic [7:0] SHIFT_MAP [128] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h7e, 8'h3d, 8'h7e, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h60, 8'h7b, 8'h0a, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
    8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00, 8'h00
  };

  assign full   = q_full;
  assign q_push = push && !q_full;

  // Look up both characters and classify the codes that change state;
  // break codes and keyboard replies carry no character
  always_comb begin
    q_item.plain_ch = scan_code[7] ? 8'h00 : PLAIN_MAP[scan_code[6:0]];
    q_item.shift_ch = scan_code[7] ? 8'h00 : SHIFT_MAP[scan_code[6:0]];
    unique case (scan_code)
      SC_LSHIFT_MAKE:  q_item.cls = CL_LSHIFT_MAKE;
      SC_RSHIFT_MAKE:  q_item.cls = CL_RSHIFT_MAKE;
      SC_LSHIFT_BREAK: q_item.cls = CL_LSHIFT_BREAK;
      SC_RSHIFT_BREAK: q_item.cls = CL_RSHIFT_BREAK;
      SC_CAPS_LOCK:    q_item.cls = CL_CAPS;
      SC_NUM_LOCK:     q_item.cls = CL_NUM;
      SC_SCROLL_LOCK:  q_item.cls = CL_SCROLL;
      SC_ACK:          q_item.cls = CL_ACK;
      SC_RESEND:       q_item.cls = CL_RESEND;
      default:         q_item.cls = CL_NONE;
    endcase
  end

endmodule

// ===== rtl/ksa_back.sv =====
module ksa_back import ksa_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  ksa_item_t   item,
  output logic        item_pop,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_leds,
  input  logic        out_full,
  output logic        out_push,
  output ksa_result_t out_word
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [AW+1:0] DEPTH_S = (AW + 2)'(QUEUE_DEPTH);
  localparam logic [7:0] ASCII_A  = 8'h41;
  localparam logic [7:0] ASCII_Z  = 8'h5a;
  localparam logic [7:0] CASE_BIT = 8'h20;

  ksa_state_t state, state_next;
  logic [1:0] shift_held, shift_held_next;
  logic [2:0] led_bits, led_bits_next;
  logic       ack_pending, ack_pending_next;
  logic [7:0] sent_byte, sent_byte_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;

  logic [7:0]    cmd_mem [QUEUE_DEPTH];
  logic [7:0]    head_data;
  logic [AW+1:0] tail_sum;
  logic [AW-1:0] tail;
  logic          wr_en;
  logic [7:0]    wr_data;
  logic          deq;
  logic          room;

  logic [7:0] sel_ch;
  logic [7:0] ch;
  logic       fold;
  logic       resend;
  logic       first_valid;
  logic       is_led;
  logic       ack_after;
  logic       will_send;
  logic       need_out;
  ksa_result_t first_word;
  ksa_result_t send_word;

  assign room     = (count != CW'(QUEUE_DEPTH));
  assign tail_sum = {2'b00, head} + {1'b0, count};
  assign tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign cfg_ready = (state == ST_EXEC) && !item_valid;

  // Character selection and fold to lower case
  always_comb begin
    sel_ch = (shift_held != 2'b00) ? item.shift_ch : item.plain_ch;
    fold   = (sel_ch >= ASCII_A) && (sel_ch <= ASCII_Z) &&
             (led_bits[2] == (shift_held != 2'b00));
    ch     = fold ? (sel_ch | CASE_BIT) : sel_ch;
  end

  // Decide what the current word produces
  always_comb begin
    resend      = (item.cls == CL_RESEND) && ack_pending;
    first_valid = (ch != 8'h00) || resend;
    is_led      = (item.cls == CL_CAPS) || (item.cls == CL_NUM) || (item.cls == CL_SCROLL);
    ack_after   = (item.cls == CL_ACK) ? 1'b0 : ack_pending;
    will_send   = !ack_after && ((count != '0) || is_led);
    need_out    = first_valid || (!is_led && will_send);
    first_word.kind  = resend ? KIND_CMD : KIND_CHAR;
    first_word.value = resend ? sent_byte : ch;
    first_word.last  = !will_send;
    send_word.kind   = KIND_CMD;
    send_word.value  = head_data;
    send_word.last   = 1'b1;
  end

  // Sequence each word: execute, queue LED bytes, send a queued byte
  always_comb begin
    state_next       = state;
    shift_held_next  = shift_held;
    led_bits_next    = led_bits;
    ack_pending_next = ack_pending;
    sent_byte_next   = sent_byte;
    item_pop         = 1'b0;
    out_push         = 1'b0;
    out_word         = send_word;
    wr_en            = 1'b0;
    wr_data          = LED_CMD;
    deq              = 1'b0;
    unique case (state)
      ST_EXEC: begin
        if (item_valid) begin
          if (!need_out || !out_full) begin
            item_pop = 1'b1;
            case (item.cls)
              CL_LSHIFT_MAKE:  shift_held_next = shift_held | 2'b01;
              CL_RSHIFT_MAKE:  shift_held_next = shift_held | 2'b10;
              CL_LSHIFT_BREAK: shift_held_next = shift_held & 2'b10;
              CL_RSHIFT_BREAK: shift_held_next = shift_held & 2'b01;
              CL_CAPS:         led_bits_next   = led_bits ^ 3'b100;
              CL_NUM:          led_bits_next   = led_bits ^ 3'b010;
              CL_SCROLL:       led_bits_next   = led_bits ^ 3'b001;
              CL_ACK:          ack_pending_next = 1'b0;
              default:         ;
            endcase
            if (is_led) begin
              wr_en      = room;
              state_next = ST_LED2;
              if (first_valid) begin
                out_push = 1'b1;
                out_word = first_word;
              end
            end else if (first_valid) begin
              out_push = 1'b1;
              out_word = first_word;
              if (will_send) begin
                state_next = ST_SEND;
              end
            end else if (will_send) begin
              out_push         = 1'b1;
              deq              = 1'b1;
              ack_pending_next = 1'b1;
              sent_byte_next   = head_data;
            end
          end
        end else if (cfg_valid) begin
          led_bits_next = cfg_leds;
          wr_en         = room;
          state_next    = ST_CFG2;
        end
      end
      ST_LED2: begin
        wr_en      = room;
        wr_data    = {5'b00000, led_bits};
        state_next = ST_SEND;
      end
      ST_CFG2: begin
        wr_en      = room;
        wr_data    = {5'b00000, led_bits};
        state_next = ST_EXEC;
      end
      ST_SEND: begin
        if ((count != '0) && !ack_pending) begin
          if (!out_full) begin
            out_push         = 1'b1;
            deq              = 1'b1;
            ack_pending_next = 1'b1;
            sent_byte_next   = head_data;
            state_next       = ST_EXEC;
          end
        end else begin
          state_next = ST_EXEC;
        end
      end
      default: state_next = ST_EXEC;
    endcase
  end

  // Queue pointer and level updates
  always_comb begin
    head_next = head;
    if (deq) begin
      head_next = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    end
    count_next = count;
    if (wr_en) begin
      count_next = count + 1'b1;
    end else if (deq) begin
      count_next = count - 1'b1;
    end
  end

  // Command memory; the head entry is read ahead, write-first
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cmd_mem[tail] <= wr_data;
    end
    if (wr_en && (tail == head_next)) begin
      head_data <= wr_data;
    end else begin
      head_data <= cmd_mem[head_next];
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_EXEC;
      shift_held  <= '0;
      led_bits    <= '0;
      ack_pending <= 1'b0;
      sent_byte   <= '0;
      head        <= '0;
      count       <= '0;
    end else begin
      state       <= state_next;
      shift_held  <= shift_held_next;
      led_bits    <= led_bits_next;
      ack_pending <= ack_pending_next;
      sent_byte   <= sent_byte_next;
      head        <= head_next;
      count       <= count_next;
    end
  end

endmodule

// ===== rtl/keyboard_scancode_to_ascii_top.sv =====
// Scan code set 1 to ASCII translator with keyboard LED command queue.
// Input: raw keyboard bytes on scan_code, taken when push is high and full low.
// Results: kind/value/last, shown while empty is low and taken with pop.
// kind 0 is a character, kind 1 a byte for the keyboard; last marks the final
// result caused by one input word.
// Configuration: initial_leds is written when cfg_valid and cfg_ready are both
// high; it loads the LED bits and queues the LED command and LED byte.
// A character or resent byte enters the result queue when its word is taken;
// a lock key passes the execute, LED and send states in that order, and its
// command byte is sent from the send state when no acknowledge is awaited.
// A new word is taken only in the execute state: a word that gives at most
// one result stays there; a character followed by a queued byte passes the
// send state, and a lock key the LED and send states, as the single write
// port of the command memory takes the command and LED byte in turn.
// A two-word input queue parts the classifier from the executing sequencer,
// and a four-word result queue lets input continue while pop is held low;
// when the result queue fills, the sequencer holds and the input queue fills.
// Reset clears shift state, LEDs, acknowledge wait and both queues.
module keyboard_scancode_to_ascii_top import ksa_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] scan_code,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] initial_leds,
  output logic       empty,
  input  logic       pop,
  output logic       kind,
  output logic [7:0] value,
  output logic       last
);

  localparam int ItemW = $bits(ksa_item_t);
  localparam int ResW  = $bits(ksa_result_t);

  logic        q_full;
  logic        q_push;
  ksa_item_t   q_item;
  logic        item_empty;
  logic        item_pop;
  logic [ItemW-1:0] item_bits;
  ksa_item_t   item;
  logic        out_full;
  logic        out_push;
  ksa_result_t out_word;
  logic [ResW-1:0] res_bits;
  ksa_result_t res;

  ksa_front u_front (
    .push      (push),
    .scan_code (scan_code),
    .full      (full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  ksa_fifo #(
    .DEPTH (ITEM_QUEUE_DEPTH),
    .WIDTH (ItemW)
  ) u_item_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_item),
    .full    (q_full),
    .rd_en   (item_pop),
    .rd_data (item_bits),
    .empty   (item_empty)
  );

  assign item = ksa_item_t'(item_bits);

  ksa_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!item_empty),
    .item       (item),
    .item_pop   (item_pop),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_leds   (initial_leds),
    .out_full   (out_full),
    .out_push   (out_push),
    .out_word   (out_word)
  );

  ksa_fifo #(
    .DEPTH (RESULT_QUEUE_DEPTH),
    .WIDTH (ResW)
  ) u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (out_word),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (res_bits),
    .empty   (empty)
  );

  // Unpack the oldest result
  assign res   = ksa_result_t'(res_bits);
  assign kind  = res.kind;
  assign value = res.value;
  assign last  = res.last;

endmodule
